/* design/iee_pkg.sv */
// shared types and constants for the infix expression evaluator
// no dependencies; used by every module of the block
package iee_pkg;

  localparam int MAG_W     = 32;
  localparam int RESULT_W  = 64;
  localparam int EVQ_DEPTH = 4;

  // characters of the expression language
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // magnitude limits, one digit of headroom over the 32-bit magnitude
  localparam logic [MAG_W+3:0] POS_LIMIT = 36'd2147483647;
  localparam logic [MAG_W+3:0] NEG_LIMIT = 36'd2147483648;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EV_MUL,
    EV_TERM,
    EV_FINAL
  } ev_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic [1:0]                 status;
  } out_item_t;

  // work handed from the character front end to the arithmetic back end
  typedef struct packed {
    ev_kind_t         kind;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             sub;
    status_t          status;
  } event_t;

endpackage

/* design/infix_expression_evaluator_core.sv */
// top level of the infix expression evaluator
// depends on iee_pkg, iee_front, iee_evq, iee_back
//
//   channel   direction  handshake             payload
//   input     in         push / full           in_item  (char_code, end_of_expression)
//   result    out        pop / empty           out_item (result_value, status)
//
// one character is taken every cycle while the event queue has room; digits and spaces
// stay in the front end, an operator after a number without error or a final character becomes an event
// the back end starts no new event while the last one is in its multiply stage (partial
// products, then combine), so events that come faster fill the four-entry queue and raise full
// a final character's event passes the queue, the multiply stage and the sum stage to the result register
// reset is synchronous; an unread result stalls the back end once the next final event reaches the sum stage
module infix_expression_evaluator_core import iee_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic   take;
  logic   evq_push;
  event_t evq_din;
  logic   evq_pop;
  event_t evq_dout;
  logic   evq_full;
  logic   evq_empty;

  assign full = evq_full;
  assign take = push && !evq_full;

  // character parsing
  iee_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (in_item),
    .ev_push (evq_push),
    .ev      (evq_din)
  );

  // event queue
  iee_evq #(
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk   (clk),
    .rst   (rst),
    .push  (evq_push),
    .din   (evq_din),
    .pop   (evq_pop),
    .dout  (evq_dout),
    .full  (evq_full),
    .empty (evq_empty)
  );

  // arithmetic and result register
  iee_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (!evq_empty),
    .ev       (evq_dout),
    .ev_pop   (evq_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  // back end never starts two events in a row
  a_issue_spacing: assert property (@(posedge clk) disable iff (rst)
    evq_pop |=> !evq_pop)
    else $error("back end started events on consecutive cycles");

  // queue is never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    evq_pop |-> !evq_empty)
    else $error("event queue read while empty");

  // an error result carries a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status != ST_OK) |-> (out_item.result_value == '0))
    else $error("error result with nonzero value");

endmodule

/* design/iee_front.sv */
// character front end: builds numbers, checks syntax, emits arithmetic events
// depends on iee_pkg
module iee_front import iee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_item_t item,
  output logic     ev_push,
  output event_t   ev
);

  // number being built and parse state
  logic [MAG_W-1:0] mag, mag_next;
  logic             neg, neg_next;
  logic             sub, sub_next;
  logic             seen, seen_next;
  status_t          err, err_next;

  logic [7:0]       c;
  logic             is_digit;
  logic             is_op;
  logic [3:0]       dval;
  logic [MAG_W+3:0] grown;
  logic             op_ev;
  status_t          fin_status;

  assign c        = item.char_code;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_op    = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR);
  assign dval     = 4'(c - CH_ZERO);
  // mag * 10 + digit as two shifts and adds
  assign grown    = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {{MAG_W{1'b0}}, dval};

  // next parse state and event for one character
  always_comb begin
    mag_next   = mag;
    neg_next   = neg;
    sub_next   = sub;
    seen_next  = seen;
    err_next   = err;
    op_ev      = 1'b0;
    fin_status = ST_OK;
    ev         = '{kind: EV_MUL, mag: mag, neg: neg, sub: sub, status: ST_OK};
    if (err == ST_OK && c != CH_SPACE) begin
      if (is_digit) begin
        seen_next = 1'b1;
        if (grown > (neg ? NEG_LIMIT : POS_LIMIT)) begin
          err_next = ST_OVERFLOW;
        end else begin
          mag_next = grown[MAG_W-1:0];
        end
      end else if (c == CH_MINUS && !seen && !neg) begin
        neg_next = 1'b1;
      end else if (is_op && seen) begin
        op_ev   = 1'b1;
        ev.kind = (c == CH_STAR) ? EV_MUL : EV_TERM;
        if (c != CH_STAR) begin
          sub_next = (c == CH_MINUS);
        end
        mag_next  = '0;
        neg_next  = 1'b0;
        seen_next = 1'b0;
      end else begin
        err_next = ST_MALFORMED;
      end
    end
    // final character closes everything and returns to the start state
    if (item.end_of_expression) begin
      fin_status = err_next;
      if (err_next == ST_OK && !seen_next) begin
        fin_status = ST_MALFORMED;
      end
      ev = '{kind: EV_FINAL, mag: mag_next, neg: neg_next, sub: sub_next,
             status: fin_status};
      mag_next  = '0;
      neg_next  = 1'b0;
      sub_next  = 1'b0;
      seen_next = 1'b0;
      err_next  = ST_OK;
    end
  end

  assign ev_push = take && (op_ev || item.end_of_expression);

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mag  <= '0;
      neg  <= 1'b0;
      sub  <= 1'b0;
      seen <= 1'b0;
      err  <= ST_OK;
    end else if (take) begin
      mag  <= mag_next;
      neg  <= neg_next;
      sub  <= sub_next;
      seen <= seen_next;
      err  <= err_next;
    end
  end

endmodule

/* design/iee_evq.sv */
// small register queue of events between front end and back end
// depends on iee_pkg
module iee_evq import iee_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t din,
  input  logic   pop,
  output event_t dout,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = q[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= din;
    end
  end

endmodule

/* design/iee_back.sv */
// arithmetic back end: product and running sum, result register
// depends on iee_pkg
module iee_back import iee_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      ev_valid,
  input  event_t    ev,
  output logic      ev_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int W    = VALUE_WIDTH;
  localparam int LO_W = (W > 32) ? 32 : W;
  localparam int HI_W = W - LO_W;

  // product kept as magnitude modulo 2^W plus a separate sign
  logic [W-1:0] prod;
  logic         prod_neg;
  logic [W-1:0] sum;

  // multiply stage registers
  logic         s1_valid;
  logic [W-1:0] s1_lo;
  logic [W-1:0] s1_hi;
  ev_kind_t     s1_kind;
  logic         s1_sign;
  logic         s1_sub;
  status_t      s1_status;

  // sum stage registers
  logic         s2_valid;
  logic         s2_final;
  logic [W-1:0] s2_term;
  logic         s2_neg;
  status_t      s2_status;

  logic         out_valid;

  logic [LO_W+MAG_W-1:0] pp_lo_full;
  logic [W-1:0]          hi_sh;
  logic [W-1:0]          prod_full;
  logic [W-1:0]          sum_next;
  logic signed [W-1:0]   sum_next_s;
  logic                  stall;
  logic                  issue;

  // partial products of the low and high halves of the product
  assign pp_lo_full = prod[LO_W-1:0] * ev.mag;

  if (HI_W > 0) begin : g_hi
    logic [HI_W+MAG_W-1:0] pp_hi_full;
    assign pp_hi_full = prod[W-1:LO_W] * ev.mag;
    assign hi_sh      = {pp_hi_full[HI_W-1:0], {LO_W{1'b0}}};
  end else begin : g_no_hi
    assign hi_sh = '0;
  end

  // combine halves, then add or subtract the finished term
  assign prod_full  = s1_lo + s1_hi;
  assign sum_next   = sum + (s2_term ^ {W{s2_neg}}) + W'(s2_neg);
  assign sum_next_s = sum_next;

  assign stall  = s2_valid && s2_final && out_valid && !pop;
  assign issue  = ev_valid && !s1_valid && !stall;
  assign ev_pop = issue;
  assign empty  = !out_valid;

  // pipeline and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
      prod      <= W'(1);
      prod_neg  <= 1'b0;
      sum       <= '0;
    end else begin
      // result register fills on a final event, empties on pop
      if (!stall && s2_valid && s2_final) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (!stall) begin
        s1_valid <= issue;
        if (issue) begin
          s1_lo     <= pp_lo_full[W-1:0];
          s1_hi     <= hi_sh;
          s1_kind   <= ev.kind;
          s1_sign   <= prod_neg ^ ev.neg;
          s1_sub    <= ev.sub;
          s1_status <= ev.status;
        end
        s2_valid <= s1_valid && (s1_kind != EV_MUL);
        if (s1_valid) begin
          if (s1_kind == EV_MUL) begin
            prod     <= prod_full;
            prod_neg <= s1_sign;
          end else begin
            prod      <= W'(1);
            prod_neg  <= 1'b0;
            s2_term   <= prod_full;
            s2_neg    <= s1_sign ^ s1_sub;
            s2_final  <= (s1_kind == EV_FINAL);
            s2_status <= s1_status;
          end
        end
        if (s2_valid) begin
          if (s2_final) begin
            sum             <= '0;
            out_item.status <= s2_status;
            out_item.result_value <= (s2_status == ST_OK) ?
                                     RESULT_W'(sum_next_s) : '0;
          end else begin
            sum <= sum_next;
          end
        end
      end
    end
  end

endmodule
